@@ src/utp_pkg.sv @@
// Types and constants for the URL target parser.
// No dependencies; imported by utp_decode, utp_outq and url_target_parser_core.
package utp_pkg;

    typedef enum logic [1:0] {
        MODE_PATH  = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_VALUE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        mode_t      part;
        logic       fend;
        logic       tend;
        logic       err;
        logic       last;
    } result_t;

    localparam logic [7:0] CH_QUERY   = 8'h3F;  // '?'
    localparam logic [7:0] CH_EQUALS  = 8'h3D;  // '='
    localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
    localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
    localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MAX     = 8'd126;

    // 0..15 for a hex digit of either case; bit 4 set otherwise
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

@@ src/utp_decode.sv @@
// Parser state and per-byte decode: turns one request byte into zero to two results.
// Depends on utp_pkg.
module utp_decode import utp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output result_t    res0,
    output result_t    res1,
    output logic [1:0] res_cnt
);

    mode_t      mode_reg, mode_next;
    esc_t       esc_reg, esc_next;
    logic [3:0] hi_reg, hi_next;
    logic       seg_reg, seg_next;
    logic       err_reg, err_next;

    logic       fail;
    logic [4:0] hex_d;
    result_t    r0, r1;
    logic [1:0] n;

    assign hex_d = hex_value(in_byte);

    always_comb begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        hi_next   = hi_reg;
        seg_next  = seg_reg;
        err_next  = err_reg;
        fail      = 1'b0;
        r0        = '0;
        r1        = '0;
        n         = 2'd0;

        if (err_reg) begin
            if (in_last) begin
                r0.part = MODE_PATH;
                r0.tend = 1'b1;
                r0.err  = 1'b1;
                n       = 2'd1;
            end
        end else begin
            case (mode_reg)
                MODE_PATH: begin
                    if (esc_reg != ESC_IDLE) begin
                        if (hex_d[4] || (esc_reg == ESC_HIGH && in_last)) begin
                            fail = 1'b1;
                        end else if (esc_reg == ESC_HIGH) begin
                            hi_next  = hex_d[3:0];
                            esc_next = ESC_LOW;
                        end else begin
                            esc_next = ESC_IDLE;
                            r0.data  = {hi_reg, hex_d[3:0]};
                            r0.valid = 1'b1;
                            r0.fend  = in_last;
                            r0.tend  = in_last;
                            n        = 2'd1;
                        end
                    end else if (in_byte == CH_QUERY) begin
                        r0.fend   = 1'b1;
                        r0.tend   = in_last;
                        n         = 2'd1;
                        mode_next = MODE_KEY;
                        seg_next  = 1'b0;
                    end else if (in_byte < CH_SPACE || in_byte > CH_MAX) begin
                        fail = 1'b1;
                    end else if (in_byte == CH_PERCENT) begin
                        if (in_last) begin
                            fail = 1'b1;
                        end else begin
                            esc_next = ESC_HIGH;
                        end
                    end else begin
                        r0.data  = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
                        r0.valid = 1'b1;
                        r0.fend  = in_last;
                        r0.tend  = in_last;
                        n        = 2'd1;
                    end
                    if (fail) begin
                        r0       = '0;
                        r0.tend  = in_last;
                        r0.err   = 1'b1;
                        n        = 2'd1;
                        esc_next = ESC_IDLE;
                        hi_next  = 4'd0;
                        err_next = 1'b1;
                    end
                end
                MODE_KEY: begin
                    if (in_byte == CH_AMP) begin
                        if (seg_reg) begin
                            r0.part = MODE_KEY;
                            r0.fend = 1'b1;
                            r1.part = MODE_VALUE;
                            r1.fend = 1'b1;
                            r1.tend = in_last;
                            n       = 2'd2;
                        end else if (in_last) begin
                            r0.part = MODE_KEY;
                            r0.tend = 1'b1;
                            n       = 2'd1;
                        end
                        seg_next = 1'b0;
                    end else if (in_byte == CH_EQUALS) begin
                        r0.part = MODE_KEY;
                        r0.fend = 1'b1;
                        r1.part = MODE_VALUE;
                        r1.fend = 1'b1;
                        r1.tend = 1'b1;
                        n       = in_last ? 2'd2 : 2'd1;
                        seg_next  = 1'b1;
                        mode_next = MODE_VALUE;
                    end else begin
                        r0.data  = in_byte;
                        r0.valid = 1'b1;
                        r0.part  = MODE_KEY;
                        r0.fend  = in_last;
                        r1.part  = MODE_VALUE;
                        r1.fend  = 1'b1;
                        r1.tend  = 1'b1;
                        n        = in_last ? 2'd2 : 2'd1;
                        seg_next = 1'b1;
                    end
                end
                MODE_VALUE: begin
                    if (in_byte == CH_AMP) begin
                        r0.part   = MODE_VALUE;
                        r0.fend   = 1'b1;
                        r0.tend   = in_last;
                        mode_next = MODE_KEY;
                        seg_next  = 1'b0;
                    end else begin
                        r0.data  = in_byte;
                        r0.valid = 1'b1;
                        r0.part  = MODE_VALUE;
                        r0.fend  = in_last;
                        r0.tend  = in_last;
                    end
                    n = 2'd1;
                end
                default: begin
                end
            endcase
        end

        // mark the final result; end of target returns everything to reset
        if (n == 2'd1) begin
            r0.last = 1'b1;
        end else if (n == 2'd2) begin
            r1.last = 1'b1;
        end
        if ((n == 2'd1 && r0.tend) || (n == 2'd2 && r1.tend)) begin
            mode_next = MODE_PATH;
            esc_next  = ESC_IDLE;
            hi_next   = 4'd0;
            seg_next  = 1'b0;
            err_next  = 1'b0;
        end
    end

    assign res0    = r0;
    assign res1    = r1;
    assign res_cnt = n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PATH;
            esc_reg  <= ESC_IDLE;
            hi_reg   <= 4'd0;
            seg_reg  <= 1'b0;
            err_reg  <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            hi_reg   <= hi_next;
            seg_reg  <= seg_next;
            err_reg  <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_esc_in_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (esc_reg != ESC_IDLE) |-> (mode_reg == MODE_PATH))
        else $error("escape pending outside path");
    a_err_in_path: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> (mode_reg == MODE_PATH && esc_reg == ESC_IDLE))
        else $error("error state with query mode or escape");
    a_tend_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && n == 2'd1 && r0.tend) |=> (mode_reg == MODE_PATH && !err_reg))
        else $error("state not cleared after end of target");
`endif

endmodule

@@ src/utp_outq.sv @@
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on utp_pkg.
module utp_outq import utp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  result_t    w0,
    input  result_t    w1,
    input  logic [1:0] push_cnt,
    output logic       room,
    output result_t    rd,
    output logic       rd_valid,
    input  logic       rd_ready
);

    result_t    mem [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign rd_valid = (cnt_reg != 3'd0);
    assign rd       = mem[head_reg];
    assign pop      = rd_valid && rd_ready;
    assign room     = (cnt_reg <= 3'd2);

    always_comb begin
        head_next = head_reg + {1'b0, pop};
        tail_next = tail_reg + push_cnt;
        cnt_next  = cnt_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[tail_reg] <= w0;
        end
        if (push_cnt == 2'd2) begin
            mem[tail_reg + 2'd1] <= w1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= 2'd0;
            tail_reg <= 2'd0;
            cnt_reg  <= 3'd0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> room)
        else $error("push into full queue");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 3'd4) |-> (tail_reg - head_reg == cnt_reg[1:0]))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ src/url_target_parser_core.sv @@
// URL request target parser: top level with input register, decode and result queue.
// Depends on utp_pkg, utp_decode and utp_outq.
//
// Takes one byte of an HTTP request target per request (s_in_last on the final
// byte) and emits path bytes percent-decoded, then query key and value bytes
// undecoded, with field ends, a target end and a parse error flag. A byte is
// taken every cycle while each byte yields at most one result and the output
// accepts results; a byte that closes a key and its value yields two, which
// leave the result port one after the other. The path from input request to
// result is one input register, then decode into a four-entry result queue,
// which absorbs the second result so that input keeps flowing while output is stalled briefly.
module url_target_parser_core import utp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic [1:0] m_part,
    output logic       m_field_end,
    output logic       m_target_end,
    output logic       m_parse_error,
    output logic       m_out_last
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       fire;
    logic       room;
    result_t    res0, res1, rd;
    logic [1:0] res_cnt, push_cnt;

    assign fire     = in_vld_reg && room;
    assign s_ready  = !in_vld_reg || fire;
    assign push_cnt = fire ? res_cnt : 2'd0;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_in_byte;
            last_reg <= s_in_last;
        end
    end

    utp_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_byte (byte_reg),
        .in_last (last_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    utp_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .w0       (res0),
        .w1       (res1),
        .push_cnt (push_cnt),
        .room     (room),
        .rd       (rd),
        .rd_valid (m_valid),
        .rd_ready (m_ready)
    );

    assign m_out_byte    = rd.data;
    assign m_byte_valid  = rd.valid;
    assign m_part        = 2'(rd.part);
    assign m_field_end   = rd.fend;
    assign m_target_end  = rd.tend;
    assign m_parse_error = rd.err;
    assign m_out_last    = rd.last;

`ifndef SYNTHESIS
    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !room) |-> !s_ready)
        else $error("request taken while input register blocked");
    a_fire_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> in_vld_reg)
        else $error("decode fired without a request");
    a_two_only_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> fire)
        else $error("results pushed without decode");
`endif

endmodule
